// ===== hdl/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants for the sorted timer queue: request and result
// payloads, the per-cell entry, the cell control bundle and the FSM states.
// ----------------------------------------------------------------------------
package stq_pkg;

  // Sizes
  localparam int STQ_NUM_TIMERS = 16;
  localparam int ID_W           = 4;
  localparam int TIME_W         = 64;

  // Request action codes
  localparam logic [1:0] ACT_SCHEDULE = 2'd0;
  localparam logic [1:0] ACT_CANCEL   = 2'd1;
  localparam logic [1:0] ACT_POLL     = 2'd2;

  // Deadline value meaning "never expires"
  localparam logic [TIME_W-1:0] DEADLINE_NEVER = '1;

  // Request payload
  typedef struct packed {
    logic [1:0]        action;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] time_now;
  } stq_in_t;

  // Result payload
  typedef struct packed {
    logic [ID_W-1:0]   fired_id;
    logic [TIME_W-1:0] fired_deadline;
  } stq_out_t;

  // One slot of the sorted list
  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
  } stq_entry_t;

  // Operation broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_REMOVE,
    CELL_DROP_HEAD,
    CELL_INSERT
  } stq_cell_op_t;

  typedef struct packed {
    stq_cell_op_t      op;
    logic [ID_W-1:0]   key_id;
    logic [TIME_W-1:0] key_deadline;
  } stq_ctrl_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_INSERT
  } stq_state_t;

endpackage

// ===== hdl/stq_cell.sv =====
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted timer list. Compares its entry with the broadcast
// key and either holds, takes its right neighbor (list closes up), takes its
// left neighbor (list opens up) or loads the new entry.
// ----------------------------------------------------------------------------
module stq_cell
  import stq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  stq_ctrl_t  ctrl,
  input  stq_entry_t left_i,
  input  stq_entry_t right_i,
  input  logic       hit_i,
  input  logic       ge_i,
  output logic       hit_o,
  output logic       ge_o,
  output stq_entry_t entry_o
);

  stq_entry_t entry_r;
  stq_entry_t entry_nxt;

  // id found here or in any earlier slot
  assign hit_o = hit_i | (entry_r.valid && (entry_r.id == ctrl.key_id));

  // new entry belongs at or before this slot (list is sorted, valid prefix)
  assign ge_o = !entry_r.valid || (entry_r.deadline >= ctrl.key_deadline);

  // next entry
  always_comb begin
    entry_nxt = entry_r;
    unique case (ctrl.op)
      CELL_HOLD: begin
        entry_nxt = entry_r;
      end
      CELL_REMOVE: begin
        if (hit_o) begin
          entry_nxt = right_i;
        end
      end
      CELL_DROP_HEAD: begin
        entry_nxt = right_i;
      end
      CELL_INSERT: begin
        if (ge_i) begin
          entry_nxt = left_i;
        end else if (ge_o) begin
          entry_nxt.valid    = 1'b1;
          entry_nxt.id       = ctrl.key_id;
          entry_nxt.deadline = ctrl.key_deadline;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  // slot register: occupied flag is reset, payload meaningful only while valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.id       <= entry_nxt.id;
    entry_r.deadline <= entry_nxt.deadline;
  end

  assign entry_o = entry_r;

endmodule

// ===== hdl/sorted_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Deadline-ordered timer list built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_req when start is high and busy is low. A schedule
//   removes any pending entry with the same id and then, unless the deadline
//   is the never value, inserts it ahead of the first entry with an equal or
//   later deadline. A cancel removes the id. A poll fires the head entry when
//   its deadline is not later than time_now.
//   Cancel and poll complete in the accept cycle. A schedule with a real
//   deadline removes in the accept cycle and inserts through the cell row
//   in the next, busy high. Removal search is a prefix OR along the row.
//   A fired timer shows on out_res with out_valid high for exactly one cycle,
//   the cycle after the poll was accepted. The receiver cannot stall; polls
//   may be issued back to back.
//   Reset clears every slot's occupied flag at once; no clearing pass.
//   When the list is full the latest entry drops off the end on insert.
// ----------------------------------------------------------------------------
module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int NUM_TIMERS = STQ_NUM_TIMERS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  stq_in_t  in_req,
  output logic     out_valid,
  output stq_out_t out_res
);

  stq_state_t state_r;
  stq_state_t state_nxt;
  stq_ctrl_t  ctrl;
  logic       accept;
  logic       fire;

  logic [ID_W-1:0]   pend_id_r;
  logic [TIME_W-1:0] pend_deadline_r;
  logic              out_valid_r;
  stq_out_t          out_res_r;

  stq_entry_t entry_w [NUM_TIMERS];
  logic       hit_w   [NUM_TIMERS];
  logic       ge_w    [NUM_TIMERS];

  assign busy   = (state_r == ST_INSERT);
  assign accept = start && !busy;

  // head of the list expires
  assign fire = entry_w[0].valid && (entry_w[0].deadline <= in_req.time_now);

  // controller: next state and cell command
  always_comb begin
    state_nxt         = state_r;
    ctrl.op           = CELL_HOLD;
    ctrl.key_id       = in_req.timer_id;
    ctrl.key_deadline = in_req.deadline;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req.action)
            ACT_SCHEDULE: begin
              ctrl.op = CELL_REMOVE;
              if (in_req.deadline != DEADLINE_NEVER) begin
                state_nxt = ST_INSERT;
              end
            end
            ACT_CANCEL: begin
              ctrl.op = CELL_REMOVE;
            end
            ACT_POLL: begin
              if (fire) begin
                ctrl.op = CELL_DROP_HEAD;
              end
            end
            default: begin
              ctrl.op = CELL_HOLD;
            end
          endcase
        end
      end
      ST_INSERT: begin
        ctrl.op           = CELL_INSERT;
        ctrl.key_id       = pend_id_r;
        ctrl.key_deadline = pend_deadline_r;
        state_nxt         = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // pending schedule key
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_id_r       <= in_req.timer_id;
      pend_deadline_r <= in_req.deadline;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept && (in_req.action == ACT_POLL) && fire;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && fire) begin
      out_res_r.fired_id       <= entry_w[0].id;
      out_res_r.fired_deadline <= entry_w[0].deadline;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // row of cells
  for (genvar j = 0; j < NUM_TIMERS; j++) begin : g_cell
    stq_entry_t left_w;
    stq_entry_t right_w;
    logic       hit_in_w;
    logic       ge_in_w;

    if (j == 0) begin : g_first
      assign left_w   = '0;
      assign hit_in_w = 1'b0;
      assign ge_in_w  = 1'b0;
    end else begin : g_mid
      assign left_w   = entry_w[j-1];
      assign hit_in_w = hit_w[j-1];
      assign ge_in_w  = ge_w[j-1];
    end

    if (j == NUM_TIMERS - 1) begin : g_last
      assign right_w = '0;
      stq_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .left_i  (left_w),
        .right_i (right_w),
        .hit_i   (hit_in_w),
        .ge_i    (ge_in_w),
        .hit_o   (hit_w[j]),
        .ge_o    (ge_w[j]),
        .entry_o (entry_w[j])
      );
    end else begin : g_inner
      assign right_w = entry_w[j+1];
      stq_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .left_i  (left_w),
        .right_i (right_w),
        .hit_i   (hit_in_w),
        .ge_i    (ge_in_w),
        .hit_o   (hit_w[j]),
        .ge_o    (ge_w[j]),
        .entry_o (entry_w[j])
      );
    end
  end

endmodule

// ===== hdl/stq_checker.sv =====
// ----------------------------------------------------------------------------
// stq_checker
// Port-level checks on the sorted timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module stq_checker
  import stq_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input stq_in_t  in_req,
  input logic     out_valid,
  input stq_out_t out_res
);

  // busy only follows an accepted schedule with a real deadline
  a_busy_after_schedule: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> ($past(start) && !$past(busy) && ($past(in_req.action) == ACT_SCHEDULE)
              && ($past(in_req.deadline) != DEADLINE_NEVER)))
    else $error("busy without a preceding schedule request");

  // the insertion phase is always followed by idle
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // a result only follows an accepted poll
  a_fire_after_poll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start) && !$past(busy) && ($past(in_req.action) == ACT_POLL)))
    else $error("result without a poll request");

  // a fired timer had expired at poll time
  a_fire_expired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.fired_deadline <= $past(in_req.time_now)))
    else $error("fired timer deadline is later than poll time");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_res   (out_res)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_timer_queue. A directed table walks the edge
// cases (empty polls, never deadlines, equal deadlines leaving in LIFO order,
// rescheduling, cancels), then random schedule/cancel/poll traffic with an
// advancing clock runs in three phases of sender idling. A local model of
// the sorted timer list predicts every fired timer not set by a typed row.
// ----------------------------------------------------------------------------
module testbench
  import stq_pkg::*;
();

  localparam int          HALF_PERIOD  = 10;
  localparam int          ITEMS_PHASE  = 550;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          WAIT_LIMIT   = 1000;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     start     = 1'b0;
  stq_in_t  in_req    = '0;
  logic     busy;
  logic     out_valid;
  stq_out_t out_res;

  // What one request should produce; typed rows override the model
  typedef struct {
    bit       typed;
    bit       fires;
    stq_out_t res;
  } req_check_t;

  typedef struct {
    stq_in_t    req;
    req_check_t chk;
  } dir_row_t;

  stq_entry_t  timer_list [STQ_NUM_TIMERS];
  req_check_t  req_checks [$];
  stq_out_t    fired_q [$];
  dir_row_t    dir_rows [$];
  logic [63:0] sweep_now;
  int          fail_count = 0;

  sorted_timer_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  always #HALF_PERIOD clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("sorted_timer_queue: mismatch");
    $finish;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("[%0t] FAIL: %s", $realtime, msg);
    end
  endfunction

  // ---------------- timer list model ----------------
  function automatic void list_drop(input int pos);
    for (int k = pos; k < STQ_NUM_TIMERS - 1; k++) timer_list[k] = timer_list[k + 1];
    timer_list[STQ_NUM_TIMERS - 1] = '0;
  endfunction

  function automatic void list_cancel(input logic [ID_W-1:0] id);
    for (int k = 0; k < STQ_NUM_TIMERS; k++) begin
      if (timer_list[k].valid && timer_list[k].id == id) begin
        list_drop(k);
        return;
      end
    end
  endfunction

  // Insert ahead of the first equal-or-later deadline (LIFO on ties)
  function automatic void list_insert(input logic [ID_W-1:0] id,
                                      input logic [TIME_W-1:0] when);
    int pos;
    pos = 0;
    while (pos < STQ_NUM_TIMERS && timer_list[pos].valid &&
           timer_list[pos].deadline < when) pos++;
    if (pos >= STQ_NUM_TIMERS) return;
    for (int k = STQ_NUM_TIMERS - 1; k > pos; k--) timer_list[k] = timer_list[k - 1];
    timer_list[pos].valid    = 1'b1;
    timer_list[pos].id       = id;
    timer_list[pos].deadline = when;
  endfunction

  // Applies one request; returns 1 when a timer fires
  function automatic bit timer_list_step(input stq_in_t req, output stq_out_t fired);
    fired = '0;
    case (req.action)
      ACT_SCHEDULE: begin
        list_cancel(req.timer_id);
        if (req.deadline != DEADLINE_NEVER) list_insert(req.timer_id, req.deadline);
      end
      ACT_CANCEL: list_cancel(req.timer_id);
      ACT_POLL: begin
        if (timer_list[0].valid && timer_list[0].deadline <= req.time_now) begin
          fired.fired_id       = timer_list[0].id;
          fired.fired_deadline = timer_list[0].deadline;
          list_drop(0);
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------- result check and request tracking ----------------
  always @(posedge clk) begin : watch_block
    req_check_t chk;
    stq_out_t   predicted;
    stq_out_t   want;
    bit         fires;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (fired_q.size() == 0) begin
          note_failure($sformatf("unexpected fire id %0d deadline %h",
                                 out_res.fired_id, out_res.fired_deadline));
        end else begin
          want = fired_q.pop_front();
          if (out_res.fired_id !== want.fired_id)
            note_failure($sformatf("fired_id expected %0d got %0d",
                                   want.fired_id, out_res.fired_id));
          if (out_res.fired_deadline !== want.fired_deadline)
            note_failure($sformatf("fired_deadline expected %h got %h",
                                   want.fired_deadline, out_res.fired_deadline));
        end
      end else if (out_valid !== 1'b0) begin
        note_failure("out_valid unknown");
      end
      // request accepted at this edge
      if (start && busy === 1'b0) begin
        chk   = req_checks.pop_front();
        fires = timer_list_step(in_req, predicted);
        if (chk.typed) begin
          fires     = chk.fires;
          predicted = chk.res;
        end
        if (fires) fired_q.push_back(predicted);
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic issue_request(input stq_in_t req, input req_check_t chk,
                               input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    req_checks.push_back(chk);
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  function automatic void add_row(input logic [1:0] act, input logic [ID_W-1:0] id,
                                  input logic [TIME_W-1:0] when,
                                  input logic [TIME_W-1:0] now, input bit typed,
                                  input bit fires, input logic [ID_W-1:0] fid,
                                  input logic [TIME_W-1:0] fdl);
    dir_row_t row;
    row.req.action           = act;
    row.req.timer_id         = id;
    row.req.deadline         = when;
    row.req.time_now         = now;
    row.chk.typed            = typed;
    row.chk.fires            = fires;
    row.chk.res.fired_id     = fid;
    row.chk.res.fired_deadline = fdl;
    dir_rows.push_back(row);
  endfunction

  // Mostly well-formed traffic around an advancing clock, some noise
  function automatic stq_in_t make_timer_request();
    int      pick;
    int      sel;
    stq_in_t r;
    pick       = $urandom_range(99);
    sel        = $urandom_range(19);
    r.timer_id = $urandom_range(15);
    r.deadline = {$urandom, $urandom};
    r.time_now = {$urandom, $urandom};
    if (pick < 45) begin
      r.action = ACT_SCHEDULE;
      case (sel)
        0:       r.deadline = DEADLINE_NEVER;
        1:       ;
        2:       r.deadline = '0;
        3:       r.deadline = DEADLINE_NEVER - 1;
        default: r.deadline = sweep_now + $urandom_range(300);
      endcase
    end else if (pick < 58) begin
      r.action = ACT_CANCEL;
    end else if (pick < 95) begin
      r.action = ACT_POLL;
      case (sel)
        0:       ;
        1:       r.time_now = DEADLINE_NEVER;
        default: begin
          r.time_now = sweep_now;
          sweep_now  = sweep_now + $urandom_range(60);
        end
      endcase
    end else begin
      r.action = ACT_UNUSED;
    end
    return r;
  endfunction

  initial begin : main_seq
    req_check_t free_chk;
    int         waited;
    free_chk = '{typed: 1'b0, fires: 1'b0, res: '0};
    foreach (timer_list[k]) timer_list[k] = '0;

    // Directed table: empty list, unused action, never deadlines, ties, reschedule
    add_row(ACT_POLL,     0,  0,                  DEADLINE_NEVER, 1, 0, 0,  0);
    add_row(ACT_CANCEL,   5,  0,                  0,              0, 0, 0,  0);
    add_row(ACT_UNUSED,   15, DEADLINE_NEVER,     DEADLINE_NEVER, 1, 0, 0,  0);
    add_row(ACT_SCHEDULE, 0,  0,                  0,              0, 0, 0,  0);
    add_row(ACT_POLL,     0,  0,                  0,              1, 1, 0,  0);
    add_row(ACT_SCHEDULE, 15, DEADLINE_NEVER,     0,              0, 0, 0,  0);
    add_row(ACT_POLL,     0,  0,                  DEADLINE_NEVER, 1, 0, 0,  0);
    add_row(ACT_SCHEDULE, 3,  100,                0,              0, 0, 0,  0);
    add_row(ACT_SCHEDULE, 4,  100,                0,              0, 0, 0,  0);
    add_row(ACT_SCHEDULE, 7,  50,                 0,              0, 0, 0,  0);
    add_row(ACT_POLL,     0,  0,                  49,             1, 0, 0,  0);
    add_row(ACT_POLL,     0,  0,                  50,             1, 1, 7,  50);
    add_row(ACT_POLL,     0,  0,                  100,            1, 1, 4,  100);
    add_row(ACT_SCHEDULE, 3,  DEADLINE_NEVER,     0,              0, 0, 0,  0);
    add_row(ACT_POLL,     0,  0,                  DEADLINE_NEVER, 1, 0, 0,  0);
    add_row(ACT_SCHEDULE, 15, DEADLINE_NEVER - 1, 0,              0, 0, 0,  0);
    add_row(ACT_SCHEDULE, 9,  DEADLINE_NEVER - 1, 0,              0, 0, 0,  0);
    add_row(ACT_SCHEDULE, 15, 200,                0,              0, 0, 0,  0);
    add_row(ACT_CANCEL,   9,  0,                  0,              0, 0, 0,  0);
    add_row(ACT_POLL,     0,  0,                  199,            1, 0, 0,  0);
    add_row(ACT_POLL,     0,  0,                  DEADLINE_NEVER, 1, 1, 15, 200);
    add_row(ACT_POLL,     0,  0,                  DEADLINE_NEVER, 1, 0, 0,  0);
    add_row(ACT_SCHEDULE, 10, 5,                  0,              0, 0, 0,  0);
    add_row(ACT_CANCEL,   10, 0,                  0,              0, 0, 0,  0);
    add_row(ACT_POLL,     0,  0,                  DEADLINE_NEVER, 1, 0, 0,  0);

    // hold synchronous reset, then release it
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) issue_request(dir_rows[i].req, dir_rows[i].chk, 25);

    // Random phases: sender idles 25%, then 75%, then never
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       sweep_now = 64'd300;
        1:       sweep_now = {$urandom, $urandom};
        default: sweep_now = DEADLINE_NEVER - 20000;
      endcase
      for (int n = 0; n < ITEMS_PHASE; n++)
        issue_request(make_timer_request(), free_chk, (phase == 0) ? 25 :
                      (phase == 1) ? 75 : 0);
    end
    @(negedge clk);
    start <= 1'b0;

    // let outstanding fires arrive, then idle for the drain period
    waited = 0;
    while (fired_q.size() != 0 && waited < WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fired_q.size() != 0)
      note_failure($sformatf("%0d expected fires never arrived", fired_q.size()));

    if (fail_count == 0) begin
      $display("sorted_timer_queue: match");
    end else begin
      $display("sorted_timer_queue: mismatch");
    end
    $finish;
  end

endmodule
